>>> hw/rtl/rbs_pkg.sv
// Package for the 2D ray versus box slab test: field widths and item types.
package rbs_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int SIZE_WIDTH  = COORD_WIDTH - 1;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] origin_x;
    logic signed [COORD_WIDTH-1:0] origin_y;
    logic signed [COORD_WIDTH-1:0] dir_x;
    logic signed [COORD_WIDTH-1:0] dir_y;
    logic        [SIZE_WIDTH-1:0]  ray_length;
    logic signed [COORD_WIDTH-1:0] box_center_x;
    logic signed [COORD_WIDTH-1:0] box_center_y;
    logic        [SIZE_WIDTH-1:0]  box_half_w;
    logic        [SIZE_WIDTH-1:0]  box_half_h;
  } ray_in_t;

  typedef struct packed {
    logic                          is_hit;
    logic        [FRAC_BITS-1:0]   entry_time;
    logic signed [COORD_WIDTH-1:0] hit_x;
    logic signed [COORD_WIDTH-1:0] hit_y;
  } ray_out_t;

endpackage

>>> hw/rtl/rbs_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
module rbs_sqrt #(
  parameter int CW = 32,
  parameter int TW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*CW-1:0] rad,
  input  logic [TW-1:0]   tag,
  output logic            out_valid,
  output logic [CW-1:0]   root,
  output logic [TW-1:0]   out_tag
);
  localparam int RW = 2 * CW;
  localparam int MW = CW + 2;
  localparam int XW = CW + 4;

  logic          v_q    [CW];
  logic [MW-1:0] rem_q  [CW-1];
  logic [RW-1:0] rad_q  [CW-1];
  logic [CW-1:0] root_q [CW];
  logic [TW-1:0] tag_q  [CW];

  genvar s;
  for (s = 0; s < CW; s++) begin : g_stage
    logic          pv;
    logic [MW-1:0] prem;
    logic [RW-1:0] prad;
    logic [CW-1:0] proot;
    logic [TW-1:0] ptag;
    logic [XW-1:0] cur;
    logic [XW-1:0] trial;
    logic          ge;

    if (s == 0) begin : g_first
      assign pv    = in_valid;
      assign prem  = '0;
      assign prad  = rad;
      assign proot = '0;
      assign ptag  = tag;
    end else begin : g_rest
      assign pv    = v_q[s-1];
      assign prem  = rem_q[s-1];
      assign prad  = rad_q[s-1];
      assign proot = root_q[s-1];
      assign ptag  = tag_q[s-1];
    end

    // Bring down the next two radicand bits and try the next root bit.
    assign cur   = {prem, prad[RW-1 -: 2]};
    assign trial = {2'b00, proot, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[s] <= 1'b0;
      end else if (en) begin
        v_q[s] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_q[s] <= {proot[CW-2:0], ge};
        tag_q[s]  <= ptag;
      end
    end

    if (s < CW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[s] <= ge ? MW'(cur - trial) : MW'(cur);
          rad_q[s] <= prad << 2;
        end
      end
    end
  end

  assign out_valid = v_q[CW-1];
  assign root      = root_q[CW-1];
  assign out_tag   = tag_q[CW-1];

endmodule

>>> hw/rtl/rbs_div.sv
// Pipelined restoring divider: overflow check stage, then one quotient bit per stage.
module rbs_div #(
  parameter int NW = 50,
  parameter int DW = 31,
  parameter int QW = 32,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic          ovf,
  output logic [TW-1:0] out_tag
);
  localparam int HW   = NW - QW;
  localparam int CMPW = (HW > DW) ? HW : DW;

  logic [HW-1:0] head;
  logic          head_ge;

  logic          pre_valid;
  logic [DW-1:0] pre_rem;
  logic [QW-1:0] pre_w;
  logic [DW-1:0] pre_den;
  logic          pre_ovf;
  logic [TW-1:0] pre_tag;

  // The quotient fits in QW bits only when the top of the numerator is below the divisor.
  assign head    = num[NW-1:QW];
  assign head_ge = (CMPW'(head) >= CMPW'(den));

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_valid <= 1'b0;
    end else if (en) begin
      pre_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_rem <= head_ge ? '0 : DW'(head);
      pre_w   <= num[QW-1:0];
      pre_den <= den;
      pre_ovf <= head_ge;
      pre_tag <= tag;
    end
  end

  logic          v_q   [QW];
  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] w_q   [QW];
  logic [DW-1:0] den_q [QW];
  logic          ovf_q [QW];
  logic [TW-1:0] tag_q [QW];

  genvar s;
  for (s = 0; s < QW; s++) begin : g_stage
    logic          pv;
    logic [DW-1:0] prem;
    logic [QW-1:0] pw;
    logic [DW-1:0] pden;
    logic          povf;
    logic [TW-1:0] ptag;
    logic [DW:0]   cur;
    logic [DW:0]   dext;
    logic          ge;

    if (s == 0) begin : g_first
      assign pv   = pre_valid;
      assign prem = pre_rem;
      assign pw   = pre_w;
      assign pden = pre_den;
      assign povf = pre_ovf;
      assign ptag = pre_tag;
    end else begin : g_rest
      assign pv   = v_q[s-1];
      assign prem = rem_q[s-1];
      assign pw   = w_q[s-1];
      assign pden = den_q[s-1];
      assign povf = ovf_q[s-1];
      assign ptag = tag_q[s-1];
    end

    // The word holds the numerator bits still to come above the quotient bits found so far.
    assign cur  = {prem, pw[QW-1]};
    assign dext = {1'b0, pden};
    assign ge   = (cur >= dext);

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[s] <= 1'b0;
      end else if (en) begin
        v_q[s] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s] <= ge ? DW'(cur - dext) : DW'(cur);
        w_q[s]   <= {pw[QW-2:0], ge};
        den_q[s] <= pden;
        ovf_q[s] <= povf;
        tag_q[s] <= ptag;
      end
    end
  end

  assign out_valid = v_q[QW-1];
  assign quo       = w_q[QW-1];
  assign ovf       = ovf_q[QW-1] | (den_q[QW-1] == '0);
  assign out_tag   = tag_q[QW-1];

endmodule

>>> hw/rtl/ray_box_slab_intersect_2d.sv
// Top level of the 2D ray versus axis-aligned box slab test pipeline.
//
//   channel | signals                  | carries
//   --------+--------------------------+-------------------------------------
//   ray     | ray_valid, ray_stall, ray | origin, direction, length, box
//   res     | res_valid, res_stall, res | hit flag, entry time, entry point
//
// One item enters per cycle while no stalled result holds the pipeline.
// The latency is set by the root unit, the motion dividers and the slab dividers,
// each of which resolves one result bit per stage.
// Reset clears only the valid bits of the stages.
// A stalled result freezes the whole pipeline, so nothing is lost or repeated.
module ray_box_slab_intersect_2d (
  input  logic             clk,
  input  logic             rst,
  input  logic             ray_valid,
  output logic             ray_stall,
  input  rbs_pkg::ray_in_t ray,
  output logic             res_valid,
  input  logic             res_stall,
  output rbs_pkg::ray_out_t res
);
  import rbs_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int FB  = FRAC_BITS;
  localparam int LW  = CW - 1;
  localparam int SW  = 2 * CW;
  localparam int NBW = CW + 2;
  localparam int SNW = NBW + FB;
  localparam int PW  = CW + FB + 1;

  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] TONE = CW'(64'd1 << FB);

  typedef struct packed {
    logic signed [CW-1:0]  px;
    logic signed [CW-1:0]  py;
    logic                  sx;
    logic                  sy;
    logic        [CW-1:0]  dxm;
    logic        [CW-1:0]  dym;
    logic        [LW-1:0]  len;
    logic signed [NBW-1:0] nlox;
    logic signed [NBW-1:0] nhix;
    logic signed [NBW-1:0] nloy;
    logic signed [NBW-1:0] nhiy;
  } sq_tag_t;

  typedef struct packed {
    logic signed [CW-1:0]  px;
    logic signed [CW-1:0]  py;
    logic                  sx;
    logic signed [NBW-1:0] nlox;
    logic signed [NBW-1:0] nhix;
    logic signed [NBW-1:0] nloy;
    logic signed [NBW-1:0] nhiy;
    logic                  lzero;
  } m_tag_t;

  typedef struct packed {
    logic                 miss;
    logic                 mxz;
    logic                 myz;
    logic signed [CW-1:0] mx;
    logic signed [CW-1:0] my;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic                 nlx;
  } t_tag_t;

  function automatic logic [CW-1:0] mag_c(input logic [CW-1:0] v);
    return v[CW-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [NBW-1:0] mag_b(input logic [NBW-1:0] v);
    return v[NBW-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic signed [CW-1:0] sat_q(input logic [CW-1:0] q, input logic ov,
                                                 input logic neg);
    logic signed [CW-1:0] r;
    if (neg) begin
      r = (ov || (q[CW-1] && (q[CW-2:0] != '0))) ? CMIN : $signed(~q + 1'b1);
    end else begin
      r = (ov || q[CW-1]) ? CMAX : $signed(q);
    end
    return r;
  endfunction

  // Offset truncated toward zero, added to the origin and saturated.
  function automatic logic signed [CW-1:0] place(input logic [PW-1:0] prod,
                                                 input logic [CW-1:0] p);
    logic [PW-1:0] adj;
    logic [CW+1:0] sum;
    adj = prod + {{(PW-FB){1'b0}}, {FB{prod[PW-1]}}};
    sum = {{2{p[CW-1]}}, p} + {adj[PW-1], adj[PW-1:FB]};
    if (sum[CW+1:CW-1] == '0 || sum[CW+1:CW-1] == '1) begin
      return sum[CW-1:0];
    end
    return sum[CW+1] ? CMIN : CMAX;
  endfunction

  logic en;
  assign en        = !(res_valid && res_stall);
  assign ray_stall = !en;

  // Stage 1: direction magnitudes, squares, box bounds.
  logic                 s1_valid;
  logic [SW-1:0]        s1_sqx, s1_sqy;
  logic [CW-1:0]        s1_dxm, s1_dym;
  logic                 s1_sx, s1_sy;
  logic signed [CW-1:0] s1_px, s1_py;
  logic [LW-1:0]        s1_len;
  logic signed [CW:0]   s1_lox, s1_hix, s1_loy, s1_hiy;
  logic [CW-1:0]        dxm, dym;

  assign dxm = mag_c(ray.dir_x);
  assign dym = mag_c(ray.dir_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= ray_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sqx <= SW'(dxm) * SW'(dxm);
      s1_sqy <= SW'(dym) * SW'(dym);
      s1_dxm <= dxm;
      s1_dym <= dym;
      s1_sx  <= ray.dir_x[CW-1];
      s1_sy  <= ray.dir_y[CW-1];
      s1_px  <= ray.origin_x;
      s1_py  <= ray.origin_y;
      s1_len <= ray.ray_length;
      s1_lox <= {ray.box_center_x[CW-1], ray.box_center_x} - {2'b00, ray.box_half_w};
      s1_hix <= {ray.box_center_x[CW-1], ray.box_center_x} + {2'b00, ray.box_half_w};
      s1_loy <= {ray.box_center_y[CW-1], ray.box_center_y} - {2'b00, ray.box_half_h};
      s1_hiy <= {ray.box_center_y[CW-1], ray.box_center_y} + {2'b00, ray.box_half_h};
    end
  end

  // Stage 2: sum of squares and bounds relative to the origin.
  logic          s2_valid;
  logic [SW-1:0] s2_sum;
  sq_tag_t       s2_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sum      <= s1_sqx + s1_sqy;
      s2_tag.px   <= s1_px;
      s2_tag.py   <= s1_py;
      s2_tag.sx   <= s1_sx;
      s2_tag.sy   <= s1_sy;
      s2_tag.dxm  <= s1_dxm;
      s2_tag.dym  <= s1_dym;
      s2_tag.len  <= s1_len;
      s2_tag.nlox <= {s1_lox[CW], s1_lox} - {{2{s1_px[CW-1]}}, s1_px};
      s2_tag.nhix <= {s1_hix[CW], s1_hix} - {{2{s1_px[CW-1]}}, s1_px};
      s2_tag.nloy <= {s1_loy[CW], s1_loy} - {{2{s1_py[CW-1]}}, s1_py};
      s2_tag.nhiy <= {s1_hiy[CW], s1_hiy} - {{2{s1_py[CW-1]}}, s1_py};
    end
  end

  logic          sq_valid;
  logic [CW-1:0] sq_root;
  sq_tag_t       sq_tag;

  rbs_sqrt #(
    .CW(CW),
    .TW($bits(sq_tag_t))
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s2_valid),
    .rad      (s2_sum),
    .tag      (s2_tag),
    .out_valid(sq_valid),
    .root     (sq_root),
    .out_tag  (sq_tag)
  );

  // Stage 3: scale each direction magnitude by the ray length.
  logic          s3_valid;
  logic [SW-2:0] s3_prx, s3_pry;
  logic [CW-1:0] s3_len;
  logic          s3_sy;
  m_tag_t        s3_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_prx       <= (SW-1)'(sq_tag.dxm) * (SW-1)'(sq_tag.len);
      s3_pry       <= (SW-1)'(sq_tag.dym) * (SW-1)'(sq_tag.len);
      s3_len       <= sq_root;
      s3_sy        <= sq_tag.sy;
      s3_tag.px    <= sq_tag.px;
      s3_tag.py    <= sq_tag.py;
      s3_tag.sx    <= sq_tag.sx;
      s3_tag.nlox  <= sq_tag.nlox;
      s3_tag.nhix  <= sq_tag.nhix;
      s3_tag.nloy  <= sq_tag.nloy;
      s3_tag.nhiy  <= sq_tag.nhiy;
      s3_tag.lzero <= (sq_root == '0);
    end
  end

  logic          mx_valid, my_valid;
  logic [LW-1:0] mx_q, my_q;
  logic          mx_ovf, my_ovf;
  m_tag_t        mx_tag;
  logic          my_sy;

  rbs_div #(
    .NW(SW-1),
    .DW(CW),
    .QW(LW),
    .TW($bits(m_tag_t))
  ) u_mdiv_x (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s3_valid),
    .num      (s3_prx),
    .den      (s3_len),
    .tag      (s3_tag),
    .out_valid(mx_valid),
    .quo      (mx_q),
    .ovf      (mx_ovf),
    .out_tag  (mx_tag)
  );

  rbs_div #(
    .NW(SW-1),
    .DW(CW),
    .QW(LW),
    .TW(1)
  ) u_mdiv_y (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s3_valid),
    .num      (s3_pry),
    .den      (s3_len),
    .tag      (s3_sy),
    .out_valid(my_valid),
    .quo      (my_q),
    .ovf      (my_ovf),
    .out_tag  (my_sy)
  );

  // Stage 4: signed motion, zero-motion checks, slab numerators.
  logic [LW-1:0] mxm, mym;
  logic          mxz, myz;
  logic          zmiss_x, zmiss_y;

  assign mxm     = mx_ovf ? '1 : mx_q;
  assign mym     = my_ovf ? '1 : my_q;
  assign mxz     = (mxm == '0);
  assign myz     = (mym == '0);
  // With no motion on an axis the origin must lie strictly inside that slab.
  assign zmiss_x = mxz && (!mx_tag.nlox[NBW-1] || mx_tag.nhix[NBW-1] || mx_tag.nhix == '0);
  assign zmiss_y = myz && (!mx_tag.nloy[NBW-1] || mx_tag.nhiy[NBW-1] || mx_tag.nhiy == '0);

  logic           s4_valid;
  logic [SNW-1:0] s4_nlx, s4_nhx, s4_nly, s4_nhy;
  logic [LW-1:0]  s4_mxm, s4_mym;
  logic           s4_ghx, s4_gly, s4_ghy;
  t_tag_t         s4_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= mx_valid && my_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_nlx      <= {mag_b(mx_tag.nlox), {FB{1'b0}}};
      s4_nhx      <= {mag_b(mx_tag.nhix), {FB{1'b0}}};
      s4_nly      <= {mag_b(mx_tag.nloy), {FB{1'b0}}};
      s4_nhy      <= {mag_b(mx_tag.nhiy), {FB{1'b0}}};
      s4_mxm      <= mxm;
      s4_mym      <= mym;
      s4_ghx      <= mx_tag.nhix[NBW-1] ^ mx_tag.sx;
      s4_gly      <= mx_tag.nloy[NBW-1] ^ my_sy;
      s4_ghy      <= mx_tag.nhiy[NBW-1] ^ my_sy;
      s4_tag.nlx  <= mx_tag.nlox[NBW-1] ^ mx_tag.sx;
      s4_tag.miss <= mx_tag.lzero || zmiss_x || zmiss_y;
      s4_tag.mxz  <= mxz;
      s4_tag.myz  <= myz;
      s4_tag.mx   <= mx_tag.sx ? $signed(~{1'b0, mxm} + 1'b1) : $signed({1'b0, mxm});
      s4_tag.my   <= my_sy ? $signed(~{1'b0, mym} + 1'b1) : $signed({1'b0, mym});
      s4_tag.px   <= mx_tag.px;
      s4_tag.py   <= mx_tag.py;
    end
  end

  logic          dlx_valid, dhx_valid, dly_valid, dhy_valid;
  logic [CW-1:0] qlx, qhx, qly, qhy;
  logic          olx, ohx, oly, ohy;
  t_tag_t        d_tag;
  logic          ghx, gly, ghy;

  rbs_div #(.NW(SNW), .DW(LW), .QW(CW), .TW($bits(t_tag_t))) u_tdiv_lx (
    .clk(clk), .rst(rst), .en(en), .in_valid(s4_valid), .num(s4_nlx), .den(s4_mxm),
    .tag(s4_tag), .out_valid(dlx_valid), .quo(qlx), .ovf(olx), .out_tag(d_tag)
  );

  rbs_div #(.NW(SNW), .DW(LW), .QW(CW), .TW(1)) u_tdiv_hx (
    .clk(clk), .rst(rst), .en(en), .in_valid(s4_valid), .num(s4_nhx), .den(s4_mxm),
    .tag(s4_ghx), .out_valid(dhx_valid), .quo(qhx), .ovf(ohx), .out_tag(ghx)
  );

  rbs_div #(.NW(SNW), .DW(LW), .QW(CW), .TW(1)) u_tdiv_ly (
    .clk(clk), .rst(rst), .en(en), .in_valid(s4_valid), .num(s4_nly), .den(s4_mym),
    .tag(s4_gly), .out_valid(dly_valid), .quo(qly), .ovf(oly), .out_tag(gly)
  );

  rbs_div #(.NW(SNW), .DW(LW), .QW(CW), .TW(1)) u_tdiv_hy (
    .clk(clk), .rst(rst), .en(en), .in_valid(s4_valid), .num(s4_nhy), .den(s4_mym),
    .tag(s4_ghy), .out_valid(dhy_valid), .quo(qhy), .ovf(ohy), .out_tag(ghy)
  );

  // Stage 5: signed, saturated slab times.
  logic                 s5_valid;
  logic signed [CW-1:0] s5_tlx, s5_thx, s5_tly, s5_thy;
  t_tag_t               s5_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (en) begin
      s5_valid <= dlx_valid && dhx_valid && dly_valid && dhy_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_tlx <= sat_q(qlx, olx, d_tag.nlx);
      s5_thx <= sat_q(qhx, ohx, ghx);
      s5_tly <= sat_q(qly, oly, gly);
      s5_thy <= sat_q(qhy, ohy, ghy);
      s5_tag <= d_tag;
    end
  end

  // Stage 6: near and far time per axis; an axis without motion adds no limit.
  logic                 s6_valid;
  logic signed [CW-1:0] s6_tnx, s6_tfx, s6_tny, s6_tfy;
  t_tag_t               s6_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (en) begin
      s6_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_tnx <= s5_tag.mxz ? '0 : ((s5_tlx < s5_thx) ? s5_tlx : s5_thx);
      s6_tfx <= s5_tag.mxz ? CMAX : ((s5_tlx < s5_thx) ? s5_thx : s5_tlx);
      s6_tny <= s5_tag.myz ? '0 : ((s5_tly < s5_thy) ? s5_tly : s5_thy);
      s6_tfy <= s5_tag.myz ? CMAX : ((s5_tly < s5_thy) ? s5_thy : s5_tly);
      s6_tag <= s5_tag;
    end
  end

  // Stage 7: entry and exit times and the hit decision.
  logic signed [CW-1:0] near_t, entry_t, exit_t;
  logic                 hit;

  assign near_t  = (s6_tnx > s6_tny) ? s6_tnx : s6_tny;
  assign entry_t = (near_t > 0) ? near_t : '0;
  assign exit_t  = (s6_tfx < s6_tfy) ? s6_tfx : s6_tfy;
  assign hit     = !s6_tag.miss && (exit_t > entry_t) && (exit_t > 0) && (entry_t < TONE);

  logic                 s7_valid;
  logic                 s7_hit;
  logic [FB-1:0]        s7_ent;
  logic signed [CW-1:0] s7_mx, s7_my, s7_px, s7_py;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
    end else if (en) begin
      s7_valid <= s6_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_hit <= hit;
      s7_ent <= entry_t[FB-1:0];
      s7_mx  <= s6_tag.mx;
      s7_my  <= s6_tag.my;
      s7_px  <= s6_tag.px;
      s7_py  <= s6_tag.py;
    end
  end

  // Stage 8: motion times entry time.
  logic                 s8_valid;
  logic                 s8_hit;
  logic [FB-1:0]        s8_ent;
  logic signed [PW-1:0] s8_prx, s8_pry;
  logic signed [CW-1:0] s8_px, s8_py;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_valid <= 1'b0;
    end else if (en) begin
      s8_valid <= s7_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_hit <= s7_hit;
      s8_ent <= s7_ent;
      s8_prx <= PW'(s7_mx) * PW'($signed({1'b0, s7_ent}));
      s8_pry <= PW'(s7_my) * PW'($signed({1'b0, s7_ent}));
      s8_px  <= s7_px;
      s8_py  <= s7_py;
    end
  end

  // Output register: hit flag, entry time and entry point, or all zero on a miss.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= s8_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (s8_hit) begin
        res.is_hit     <= 1'b1;
        res.entry_time <= s8_ent;
        res.hit_x      <= place(s8_prx, s8_px);
        res.hit_y      <= place(s8_pry, s8_py);
      end else begin
        res <= '0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.is_hit) |-> (res.entry_time == '0 && res.hit_x == '0 && res.hit_y == '0))
    else $error("missed item carries nonzero time or point");

  a_reset_clear: assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

  a_take: assert property (@(posedge clk) disable iff (rst)
    (ray_valid && !ray_stall) |=> s1_valid)
    else $error("accepted item did not reach the first stage");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (s8_valid && !en) |=> s8_valid)
    else $error("item dropped from the last stage while stalled");
`endif

endmodule

>>> tb/sv/tb_ray_box_slab_intersect_2d.sv
// Testbench for the 2D ray versus box slab test: random and corner rays checked against a predictor.
`timescale 1ns / 100ps

module tb_ray_box_slab_intersect_2d;
  import rbs_pkg::*;

  localparam int LATENCY = 3 * COORD_WIDTH + 10;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam longint CMAX = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
  localparam longint CMIN = -CMAX - 1;
  localparam longint TONE = 64'sd1 <<< FRAC_BITS;

  logic clk;
  logic rst;
  logic ray_valid;
  logic ray_stall;
  ray_in_t ray;
  logic res_valid;
  logic res_stall;
  ray_out_t res;

  ray_in_t pending_rays[$];
  ray_out_t expected_hits[$];
  int error_count;
  int idle_cycles;
  bit stimulus_done;
  bit in_taken;
  int hold_off;
  int send_gap;
  int recv_gap;

  ray_box_slab_intersect_2d DUT (
    .clk(clk),
    .rst(rst),
    .ray_valid(ray_valid),
    .ray_stall(ray_stall),
    .ray(ray),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint sat_coord(longint x);
    if (x > CMAX) return CMAX;
    if (x < CMIN) return CMIN;
    return x;
  endfunction

  function automatic longint div_trunc(longint n, longint d);
    longint unsigned q;
    q = (n < 0 ? -n : n) / (d < 0 ? -d : d);
    return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned s);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic ray_out_t slab_hit(ray_in_t r);
    ray_out_t o;
    longint p[2], d[2], c[2], h[2], m[2];
    longint unsigned mg[2];
    longint unsigned dir_len;
    longint entry, exit_t, lo, hi, t1, t2, tn, tf;
    o = '0;
    p[0] = r.origin_x; p[1] = r.origin_y;
    d[0] = r.dir_x; d[1] = r.dir_y;
    c[0] = r.box_center_x; c[1] = r.box_center_y;
    h[0] = longint'(r.box_half_w); h[1] = longint'(r.box_half_h);
    if (d[0] == 0 && d[1] == 0) return o;
    for (int i = 0; i < 2; i++) mg[i] = d[i] < 0 ? -d[i] : d[i];
    dir_len = root_floor(mg[0] * mg[0] + mg[1] * mg[1]);
    if (dir_len == 0) return o;
    for (int i = 0; i < 2; i++) begin
      // Product fits 64 bits: 32-bit magnitude times 31-bit length.
      m[i] = longint'(mg[i] * longint'(r.ray_length) / dir_len);
      if (d[i] < 0) m[i] = -m[i];
    end
    entry = 0;
    exit_t = CMAX;
    for (int i = 0; i < 2; i++) begin
      lo = c[i] - h[i];
      hi = c[i] + h[i];
      if (m[i] != 0) begin
        t1 = sat_coord(div_trunc((lo - p[i]) * TONE, m[i]));
        t2 = sat_coord(div_trunc((hi - p[i]) * TONE, m[i]));
        tn = t1 < t2 ? t1 : t2;
        tf = t1 < t2 ? t2 : t1;
        if (tn > entry) entry = tn;
        if (tf < exit_t) exit_t = tf;
      end else if (p[i] <= lo || p[i] >= hi) begin
        return o;
      end
    end
    if (exit_t > entry && exit_t > 0 && entry < TONE) begin
      o.is_hit = 1'b1;
      o.entry_time = entry[FRAC_BITS-1:0];
      o.hit_x = COORD_WIDTH'(sat_coord(p[0] + div_trunc(m[0] * entry, TONE)));
      o.hit_y = COORD_WIDTH'(sat_coord(p[1] + div_trunc(m[1] * entry, TONE)));
    end
    return o;
  endfunction

  function automatic int short_or_long_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h8000_0000 | $urandom_range(0, 3);
      2: return 32'h7fff_ffff - $urandom_range(0, 3);
      default: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
    endcase
  endfunction

  function automatic logic [30:0] rand_size();
    case ($urandom_range(0, 4))
      0: return 31'($urandom);
      1: return 31'(31'h7fff_ffff - $urandom_range(0, 3));
      2: return 31'($urandom_range(0, 3));
      default: return 31'($urandom_range(0, 32'h0010_0000));
    endcase
  endfunction

  // Well-formed rays start near the box and aim toward its center, so most hit.
  function automatic ray_in_t aimed_ray();
    ray_in_t r;
    r.box_center_x = $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
    r.box_center_y = $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
    r.box_half_w = 31'($urandom_range(1, 32'h0008_0000));
    r.box_half_h = 31'($urandom_range(1, 32'h0008_0000));
    r.origin_x = r.box_center_x + $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
    r.origin_y = r.box_center_y + $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
    r.dir_x = r.box_center_x - r.origin_x + $signed($urandom_range(0, 32'h2000)) - 32'sh1000;
    r.dir_y = r.box_center_y - r.origin_y + $signed($urandom_range(0, 32'h2000)) - 32'sh1000;
    r.ray_length = 31'($urandom_range(0, 32'h0060_0000));
    return r;
  endfunction

  function automatic ray_in_t noise_ray();
    ray_in_t r;
    r.origin_x = rand_coord();
    r.origin_y = rand_coord();
    r.dir_x = ($urandom_range(0, 9) == 0) ? 32'd0 : rand_coord();
    r.dir_y = ($urandom_range(0, 9) == 0) ? 32'd0 : rand_coord();
    r.ray_length = rand_size();
    r.box_center_x = rand_coord();
    r.box_center_y = rand_coord();
    r.box_half_w = rand_size();
    r.box_half_h = rand_size();
    return r;
  endfunction

  function automatic ray_in_t make_ray(int ox, int oy, int dx, int dy, int unsigned len,
                                        int cx, int cy, int unsigned hw, int unsigned hh);
    ray_in_t r;
    r.origin_x = ox; r.origin_y = oy; r.dir_x = dx; r.dir_y = dy;
    r.ray_length = 31'(len); r.box_center_x = cx; r.box_center_y = cy;
    r.box_half_w = 31'(hw); r.box_half_h = 31'(hh);
    return r;
  endfunction

  function automatic void queue_ray(ray_in_t r);
    pending_rays.insert(pending_rays.size(), r);
  endfunction

  initial begin
    ray_in_t r;
    // Head-on hit, miss, zero direction, zero length inside and outside.
    queue_ray(make_ray(0, 0, 32'h10000, 0, 32'h100000, 32'h50000, 0,
                       32'h10000, 32'h10000));
    queue_ray(make_ray(0, 0, 32'h10000, 0, 32'h20000, 32'h50000, 0,
                       32'h10000, 32'h10000));
    queue_ray(make_ray(0, 0, 0, 0, 32'h100000, 0, 0, 32'h10000, 32'h10000));
    queue_ray(make_ray(0, 0, 32'h10000, 32'h10000, 0, 0, 0,
                       32'h10000, 32'h10000));
    queue_ray(make_ray(32'h30000, 0, 32'h10000, 0, 0, 0, 0,
                       32'h10000, 32'h10000));
    // Origin exactly on a slab boundary with no motion on that axis.
    queue_ray(make_ray(32'h10000, 0, 0, 32'h10000, 32'h10000, 0, 0,
                       32'h10000, 32'h10000));
    // Negative directions, diagonal, origin inside the box.
    queue_ray(make_ray(32'h80000, 32'h80000, -32'sh10000, -32'sh10000,
                       32'h200000, 0, 0, 32'h20000, 32'h20000));
    queue_ray(make_ray(0, 0, 32'h30000, -32'sh40000, 32'h10000, 0, 0,
                       32'h20000, 32'h20000));
    // Tiny motion: slab times saturate and tie.
    queue_ray(make_ray(0, 0, 32'h7fffffff, 1, 1, 32'h7fffffff, 32'h7fffffff,
                       32'h7fffffff, 32'h7fffffff));
    queue_ray(make_ray(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                       31'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                       31'h7fffffff, 31'h7fffffff));
    queue_ray(make_ray(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                       31'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0));
    queue_ray(make_ray(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                       31'h7fffffff, 32'hffffffff, 32'hffffffff,
                       31'h7fffffff, 31'h7fffffff));
    queue_ray(make_ray(0, 0, 0, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 450; i++) begin
      r = ($urandom_range(0, 99) < 70) ? aimed_ray() : noise_ray();
      queue_ray(r);
    end
  end

  // Driver: payload changes only at the falling edge after an acceptance or while idle.
  // Acceptance is taken from the flag sampled at the rising edge, since the stall
  // seen at the falling edge may already belong to the next cycle.
  always @(negedge clk) begin
    if (rst) begin
      ray_valid <= 1'b0;
      send_gap <= 0;
    end else if (!ray_valid || in_taken) begin
      if (in_taken) expected_hits.insert(expected_hits.size(), slab_hit(ray));
      if (ray_valid && pending_rays.size() == 0) begin
        ray_valid <= 1'b0;
      end else if (send_gap > 0) begin
        ray_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_rays.size() > 0) begin
        ray <= pending_rays.pop_front();
        ray_valid <= 1'b1;
        send_gap <= short_or_long_gap();
      end else begin
        ray_valid <= 1'b0;
        stimulus_done <= 1'b1;
      end
    end
  end

  // Receiver stall, with one long hold-off early to fill the pipeline.
  always @(negedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      hold_off <= 3 * LATENCY;
      recv_gap <= 0;
    end else if (hold_off > 0 && pending_rays.size() < 430) begin
      res_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else if (recv_gap > 0) begin
      res_stall <= 1'b1;
      recv_gap <= recv_gap - 1;
    end else begin
      res_stall <= 1'b0;
      recv_gap <= short_or_long_gap();
    end
  end

  // Monitor and watchdog.
  always @(posedge clk) begin
    ray_out_t want;
    in_taken <= !rst && ray_valid && !ray_stall;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((ray_valid && !ray_stall) || (res_valid && !res_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (res_valid && !res_stall) begin
        // The driver records a ray at the next falling edge; an empty queue with a ray accepted now is reported apart.
        if (expected_hits.size() == 0 && ray_valid && !ray_stall) begin
          $error("result arrived in the same cycle its ray was accepted");
          error_count++;
        end else if (expected_hits.size() == 0) begin
          $error("unexpected result: is_hit %0d", res.is_hit);
          error_count++;
        end else begin
          want = expected_hits.pop_front();
          if (res.is_hit !== want.is_hit) begin
            $error("is_hit: expected %0d, actual %0d", want.is_hit, res.is_hit);
            error_count++;
          end
          if (res.entry_time !== want.entry_time) begin
            $error("entry_time: expected %0h, actual %0h", want.entry_time, res.entry_time);
            error_count++;
          end
          if (res.hit_x !== want.hit_x) begin
            $error("hit_x: expected %0h, actual %0h", want.hit_x, res.hit_x);
            error_count++;
          end
          if (res.hit_y !== want.hit_y) begin
            $error("hit_y: expected %0h, actual %0h", want.hit_y, res.hit_y);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    error_count = 0;
    stimulus_done = 1'b0;
    rst = 1'b1;
    ray_valid = 1'b0;
    ray = '0;
    res_stall = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    fork
      begin
        wait (stimulus_done && expected_hits.size() == 0);
        repeat (LATENCY + 20) @(posedge clk);
      end
      begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    join_any
    if (error_count == 0 && expected_hits.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> ray_box_slab_intersect_2d.f
hw/rtl/rbs_pkg.sv
hw/rtl/rbs_sqrt.sv
hw/rtl/rbs_div.sv
hw/rtl/ray_box_slab_intersect_2d.sv
tb/sv/tb_ray_box_slab_intersect_2d.sv
